// ----- rtl/ddn_pkg.sv -----
`default_nettype none
package ddn_pkg;

  // Configuration register indexes
  localparam logic [2:0] REG_SOURCE_WIDTH   = 3'd0;
  localparam logic [2:0] REG_SOURCE_HEIGHT  = 3'd1;
  localparam logic [2:0] REG_DST_WIDTH      = 3'd2;
  localparam logic [2:0] REG_DST_HEIGHT     = 3'd3;
  localparam logic [2:0] REG_DEPTH_ENCODING = 3'd4;
  localparam logic [2:0] REG_DEPTH_SCALE    = 3'd5;
  localparam logic [2:0] REG_DEPTH_LIMIT    = 3'd6;

  localparam int DEF_MAX_WIDTH  = 4096;
  localparam int DEF_MAX_HEIGHT = 4096;

  localparam logic [12:0] RST_SOURCE_WIDTH  = 13'd640;
  localparam logic [12:0] RST_SOURCE_HEIGHT = 13'd480;
  localparam logic [12:0] RST_DST_WIDTH     = 13'd640;
  localparam logic [12:0] RST_DST_HEIGHT    = 13'd480;
  localparam logic [23:0] RST_DEPTH_SCALE   = 24'd16777;
  localparam logic [31:0] RST_DEPTH_LIMIT   = 32'd655360;

  localparam logic ENC_COUNT = 1'b0;
  localparam logic ENC_FLOAT = 1'b1;

  // Zero scale falls back to about 1 mm per count
  localparam logic [23:0] FALLBACK_SCALE = 24'd16777;

  // float32: exponent at or above this is 65536 m or more
  localparam logic [7:0] EXP_SATURATE = 8'd143;
  // right shift of {mantissa, 8'b0} is EXP_POINT - exponent
  localparam logic [7:0] EXP_POINT    = 8'd142;
  localparam logic [7:0] EXP_SPECIAL  = 8'hFF;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = 2;

  // one conversion stage, then one stage per quotient bit
  localparam int QUOT_BITS   = 17;
  localparam int PIPE_STAGES = QUOT_BITS + 1;

  typedef struct packed {
    logic [12:0] source_width;
    logic [12:0] source_height;
    logic [12:0] dst_width;
    logic [12:0] dst_height;
    logic        depth_encoding;
    logic [23:0] depth_scale;
    logic [31:0] depth_limit;
  } cfg_t;

  typedef struct packed {
    logic [31:0] raw;
    logic        row_end;
    logic        frame_end;
  } item_t;

endpackage
`default_nettype wire

// ----- rtl/ddn_regs.sv -----
`default_nettype none
module ddn_regs import ddn_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  output cfg_t             cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        REG_SOURCE_WIDTH:   cfg_nxt.source_width   = cfg_data[12:0];
        REG_SOURCE_HEIGHT:  cfg_nxt.source_height  = cfg_data[12:0];
        REG_DST_WIDTH:      cfg_nxt.dst_width      = cfg_data[12:0];
        REG_DST_HEIGHT:     cfg_nxt.dst_height     = cfg_data[12:0];
        REG_DEPTH_ENCODING: cfg_nxt.depth_encoding = cfg_data[0];
        REG_DEPTH_SCALE:    cfg_nxt.depth_scale    = cfg_data[23:0];
        REG_DEPTH_LIMIT:    cfg_nxt.depth_limit    = cfg_data;
        default:            cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.source_width   <= RST_SOURCE_WIDTH;
      cfg_r.source_height  <= RST_SOURCE_HEIGHT;
      cfg_r.dst_width      <= RST_DST_WIDTH;
      cfg_r.dst_height     <= RST_DST_HEIGHT;
      cfg_r.depth_encoding <= ENC_COUNT;
      cfg_r.depth_scale    <= RST_DEPTH_SCALE;
      cfg_r.depth_limit    <= RST_DEPTH_LIMIT;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/ddn_front.sv -----
`default_nettype none
module ddn_front import ddn_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire cfg_t        cfg,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [31:0] in_raw_sample,
  input  wire logic        queue_full,
  output logic             push,
  output item_t            push_item
);

  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int HW  = $clog2(MAX_HEIGHT + 1);
  localparam int CAW = 2 * WW;
  localparam int RAW = 2 * HW;
  localparam int CAE = CAW + 1;
  localparam int RAE = RAW + 1;

  logic [WW-1:0]  w, ow;
  logic [HW-1:0]  h, oh;

  logic [WW-1:0]  src_col_r, src_col_nxt, dst_col_r, dst_col_nxt;
  logic [HW-1:0]  src_row_r, src_row_nxt, dst_row_r, dst_row_nxt;
  logic [CAW-1:0] col_target_acc_r, col_target_acc_nxt;
  logic [CAW-1:0] col_base_acc_r, col_base_acc_nxt;
  logic [RAW-1:0] row_target_acc_r, row_target_acc_nxt;
  logic [RAW-1:0] row_base_acc_r, row_base_acc_nxt;

  logic row_hit, col_hit, last_col, last_row, accept, row_done, frame_done;

  // sizes clamped: source to 1..MAX, output to 1..source (no upscaling)
  always_comb begin
    if (cfg.source_width == 13'd0) begin
      w = WW'(1);
    end else if (32'(cfg.source_width) > 32'(MAX_WIDTH)) begin
      w = WW'(MAX_WIDTH);
    end else begin
      w = WW'(cfg.source_width);
    end
    if (cfg.source_height == 13'd0) begin
      h = HW'(1);
    end else if (32'(cfg.source_height) > 32'(MAX_HEIGHT)) begin
      h = HW'(MAX_HEIGHT);
    end else begin
      h = HW'(cfg.source_height);
    end
    if (cfg.dst_width == 13'd0) begin
      ow = WW'(1);
    end else if (32'(cfg.dst_width) > 32'(w)) begin
      ow = w;
    end else begin
      ow = WW'(cfg.dst_width);
    end
    if (cfg.dst_height == 13'd0) begin
      oh = HW'(1);
    end else if (32'(cfg.dst_height) > 32'(h)) begin
      oh = h;
    end else begin
      oh = HW'(cfg.dst_height);
    end
  end

  always_comb begin
    row_hit = (dst_row_r < oh) &&
              (RAE'(row_target_acc_r) < RAE'(row_base_acc_r) + RAE'(oh));
    col_hit = (dst_col_r < ow) &&
              (CAE'(col_target_acc_r) < CAE'(col_base_acc_r) + CAE'(ow));
    last_col   = (WW'(dst_col_r + WW'(1)) == ow);
    last_row   = (HW'(dst_row_r + HW'(1)) == oh);
    row_done   = (WW'(src_col_r + WW'(1)) >= w);
    frame_done = (HW'(src_row_r + HW'(1)) >= h);

    in_stall = queue_full;
    accept   = in_valid && !queue_full;
    push     = accept && row_hit && col_hit;
    push_item.raw       = in_raw_sample;
    push_item.row_end   = last_col;
    push_item.frame_end = last_col && last_row;
  end

  always_comb begin
    src_col_nxt        = src_col_r;
    src_row_nxt        = src_row_r;
    dst_col_nxt        = dst_col_r;
    dst_row_nxt        = dst_row_r;
    col_target_acc_nxt = col_target_acc_r;
    col_base_acc_nxt   = col_base_acc_r;
    row_target_acc_nxt = row_target_acc_r;
    row_base_acc_nxt   = row_base_acc_r;
    if (accept) begin
      col_base_acc_nxt = col_base_acc_r + CAW'(ow);
      if (row_hit && col_hit) begin
        dst_col_nxt        = dst_col_r + WW'(1);
        col_target_acc_nxt = col_target_acc_r + CAW'(w);
      end
      if (row_done) begin
        src_col_nxt        = '0;
        dst_col_nxt        = '0;
        col_base_acc_nxt   = '0;
        col_target_acc_nxt = '0;
        if (row_hit) begin
          dst_row_nxt        = dst_row_r + HW'(1);
          row_target_acc_nxt = row_target_acc_r + RAW'(h);
        end
        row_base_acc_nxt = row_base_acc_r + RAW'(oh);
        if (frame_done) begin
          src_row_nxt        = '0;
          dst_row_nxt        = '0;
          row_base_acc_nxt   = '0;
          row_target_acc_nxt = '0;
        end else begin
          src_row_nxt = src_row_r + HW'(1);
        end
      end else begin
        src_col_nxt = src_col_r + WW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_col_r        <= '0;
      src_row_r        <= '0;
      dst_col_r        <= '0;
      dst_row_r        <= '0;
      col_target_acc_r <= '0;
      col_base_acc_r   <= '0;
      row_target_acc_r <= '0;
      row_base_acc_r   <= '0;
    end else begin
      src_col_r        <= src_col_nxt;
      src_row_r        <= src_row_nxt;
      dst_col_r        <= dst_col_nxt;
      dst_row_r        <= dst_row_nxt;
      col_target_acc_r <= col_target_acc_nxt;
      col_base_acc_r   <= col_base_acc_nxt;
      row_target_acc_r <= row_target_acc_nxt;
      row_base_acc_r   <= row_base_acc_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/ddn_queue.sv -----
`default_nettype none
module ddn_queue import ddn_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  push,
  input  wire item_t push_item,
  output logic       full,
  input  wire logic  pop,
  output item_t      head,
  output logic       empty
);

  item_t                mem_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [QUEUE_AW:0]    count_r, count_nxt;
  logic                 do_push, do_pop;

  assign full    = (count_r == (QUEUE_AW + 1)'(QUEUE_DEPTH));
  assign empty   = (count_r == '0);
  assign head    = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + (QUEUE_AW + 1)'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - (QUEUE_AW + 1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + QUEUE_AW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + QUEUE_AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/ddn_back.sv -----
`default_nettype none
module ddn_back import ddn_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire cfg_t  cfg,
  input  wire logic  queue_empty,
  input  wire item_t head,
  output logic       pop,
  output logic       out_valid,
  input  wire logic  out_stall,
  output logic [16:0] out_normalized_depth,
  output logic       out_row_end,
  output logic       out_frame_end
);

  localparam int LAST = PIPE_STAGES - 1;

  logic        valid_r   [PIPE_STAGES];
  logic [31:0] rem_r     [PIPE_STAGES];
  logic [16:0] quot_r    [PIPE_STAGES];
  logic        row_end_r [PIPE_STAGES];
  logic        frame_end_r [PIPE_STAGES];

  logic [31:0] rem_nxt  [PIPE_STAGES];
  logic [16:0] quot_nxt [PIPE_STAGES];

  logic        advance;
  logic [31:0] mx;
  logic [23:0] scale;
  logic [39:0] product;
  logic [31:0] count_depth;
  logic [7:0]  expo, expo_eff, shift;
  logic [23:0] mant;
  logic [31:0] float_depth;
  logic        bad, over;
  logic [32:0] trial;

  // whole pipeline moves when its last stage is empty or being taken
  assign advance = !valid_r[LAST] || !out_stall;
  assign pop     = advance && !queue_empty;

  assign out_valid            = valid_r[LAST];
  assign out_normalized_depth = quot_r[LAST];
  assign out_row_end          = row_end_r[LAST];
  assign out_frame_end        = frame_end_r[LAST];

  // conversion to Q16.16 metres and clip against the depth limit
  always_comb begin
    mx          = (cfg.depth_limit == 32'd0) ? 32'd1 : cfg.depth_limit;
    scale       = (cfg.depth_scale == 24'd0) ? FALLBACK_SCALE : cfg.depth_scale;
    product     = 40'(head.raw[15:0]) * 40'(scale);
    count_depth = product[39:8];

    expo     = head.raw[30:23];
    expo_eff = (expo == 8'd0) ? 8'd1 : expo;
    mant     = {(expo != 8'd0), head.raw[22:0]};
    shift    = EXP_POINT - expo_eff;
    if (shift >= 8'd32) begin
      float_depth = 32'd0;
    end else begin
      float_depth = {mant, 8'd0} >> shift[4:0];
    end

    if (cfg.depth_encoding == ENC_FLOAT) begin
      bad  = head.raw[31] || (expo == EXP_SPECIAL) || (head.raw[30:0] == 31'd0);
      over = (expo_eff >= EXP_SATURATE) || (float_depth > mx);
    end else begin
      bad  = (head.raw[15:0] == 16'd0);
      over = (count_depth > mx);
    end

    rem_nxt[0]  = (bad || over) ? mx :
                  ((cfg.depth_encoding == ENC_FLOAT) ? float_depth : count_depth);
    quot_nxt[0] = '0;
    trial       = '0;

    // restoring division, one quotient bit per stage, MSB first
    for (int k = 1; k < PIPE_STAGES; k++) begin
      if (k == 1) begin
        trial = {1'b0, rem_r[k-1]};
      end else begin
        trial = {rem_r[k-1], 1'b0};
      end
      quot_nxt[k] = quot_r[k-1];
      if (trial >= {1'b0, mx}) begin
        rem_nxt[k]                = 32'(trial - {1'b0, mx});
        quot_nxt[k][PIPE_STAGES-1-k] = 1'b1;
      end else begin
        rem_nxt[k] = trial[31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < PIPE_STAGES; k++) begin
        valid_r[k] <= 1'b0;
      end
    end else if (advance) begin
      valid_r[0] <= !queue_empty;
      for (int k = 1; k < PIPE_STAGES; k++) begin
        valid_r[k] <= valid_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rem_r[0]       <= rem_nxt[0];
      quot_r[0]      <= quot_nxt[0];
      row_end_r[0]   <= head.row_end;
      frame_end_r[0] <= head.frame_end;
      for (int k = 1; k < PIPE_STAGES; k++) begin
        rem_r[k]       <= rem_nxt[k];
        quot_r[k]      <= quot_nxt[k];
        row_end_r[k]   <= row_end_r[k-1];
        frame_end_r[k] <= frame_end_r[k-1];
      end
    end
  end

endmodule
`default_nettype wire

// ----- rtl/depth_decimate_normalize_top.sv -----
`default_nettype none
// Nearest-neighbour depth downscaler with normalisation. Source pixels are
// taken one per cycle in raster order while in_stall is low; the front end
// keeps those that the resampling selects and queues them, and the back end
// converts each to Q16.16 metres, clips it to the depth limit and divides by
// it through a 17-stage restoring divider. Sustained rate is one transfer
// per cycle on both sides while neither side stalls; out_valid for a kept
// pixel rises once it has passed the queue entry, the conversion stage and
// one divider stage per quotient bit, in that order. Back-pressure on the
// output freezes the divider pipeline, and the input stalls once the
// four-entry queue fills. Configuration writes are taken in any cycle but
// must only be issued while no pixel is in flight.
module depth_decimate_normalize_top import ddn_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [31:0] in_raw_sample,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [16:0]      out_normalized_depth,
  output logic             out_row_end,
  output logic             out_frame_end
);

  cfg_t  cfg;
  item_t push_item, head;
  logic  push, queue_full, pop, queue_empty;

  ddn_regs u_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  ddn_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_raw_sample (in_raw_sample),
    .queue_full    (queue_full),
    .push          (push),
    .push_item     (push_item)
  );

  ddn_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (queue_full),
    .pop       (pop),
    .head      (head),
    .empty     (queue_empty)
  );

  ddn_back u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg                  (cfg),
    .queue_empty          (queue_empty),
    .head                 (head),
    .pop                  (pop),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_normalized_depth (out_normalized_depth),
    .out_row_end          (out_row_end),
    .out_frame_end        (out_frame_end)
  );

endmodule
`default_nettype wire

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top import ddn_pkg::*;;

  localparam int HOLD_OFF    = PIPE_STAGES + QUEUE_DEPTH + 8;
  localparam int STALL_LIMIT = 2000;
  localparam int PHASE_ITEMS = 190;
  localparam int MAX_REPORTS = 10;

  localparam logic [31:0] COUNT_CASES [7] = '{
    32'h0000_0000, 32'h0000_0001, 32'h0000_FFFF, 32'hFFFF_0000,
    32'hFFFF_FFFF, 32'h0000_2710, 32'hA5A5_2711
  };

  // signed zeros, NaNs, infinities, negative, subnormal edges, normal range edges
  localparam logic [31:0] FLOAT_CASES [16] = '{
    32'h0000_0000, 32'h8000_0000, 32'h7FC0_0000, 32'h7F80_0001,
    32'h7F80_0000, 32'hFF80_0000, 32'hBF80_0000, 32'h0000_0001,
    32'h007F_FFFF, 32'h0080_0000, 32'h3780_0000, 32'h3F80_0000,
    32'h42C8_0000, 32'h477F_FFFF, 32'h4780_0000, 32'h7F7F_FFFF
  };

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  typedef struct {
    logic [16:0] depth;
    logic        row_end;
    logic        frame_end;
  } kept_pixel_t;

  // Tracks the decimation position and normalises every kept pixel.
  class depth_tracker;
    cfg_t        regs;
    int unsigned src_col, src_row, dst_col, dst_row;
    int unsigned col_target, col_base, row_target, row_base;
    kept_pixel_t due[$];
    int          errors;
    int          checked;

    function new();
      regs.source_width   = RST_SOURCE_WIDTH;
      regs.source_height  = RST_SOURCE_HEIGHT;
      regs.dst_width      = RST_DST_WIDTH;
      regs.dst_height     = RST_DST_HEIGHT;
      regs.depth_encoding = ENC_COUNT;
      regs.depth_scale    = RST_DEPTH_SCALE;
      regs.depth_limit    = RST_DEPTH_LIMIT;
      src_col = 0; src_row = 0; dst_col = 0; dst_row = 0;
      col_target = 0; col_base = 0; row_target = 0; row_base = 0;
      errors = 0;
      checked = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] data);
      case (idx)
        REG_SOURCE_WIDTH:   regs.source_width   = data[12:0];
        REG_SOURCE_HEIGHT:  regs.source_height  = data[12:0];
        REG_DST_WIDTH:      regs.dst_width      = data[12:0];
        REG_DST_HEIGHT:     regs.dst_height     = data[12:0];
        REG_DEPTH_ENCODING: regs.depth_encoding = data[0];
        REG_DEPTH_SCALE:    regs.depth_scale    = data[23:0];
        REG_DEPTH_LIMIT:    regs.depth_limit    = data;
        default: ;
      endcase
    endfunction

    function int unsigned fit_size(logic [12:0] v, int unsigned hi);
      if (v == 0) return 1;
      if (v > hi) return hi;
      return v;
    endfunction

    // Q16.16 metres; bad flags zero, negative and non-finite depths
    function longint unsigned depth_q16(logic [31:0] raw, output bit bad);
      longint unsigned cnt, sc, man;
      logic [7:0]      ex;
      bad = 1'b0;
      if (regs.depth_encoding == ENC_COUNT) begin
        cnt = raw[15:0];
        sc = (regs.depth_scale != 0) ? 64'(regs.depth_scale) : 64'(FALLBACK_SCALE);
        if (cnt == 0) begin
          bad = 1'b1;
          return 0;
        end
        return (cnt * sc) >> 8;
      end
      ex = raw[30:23];
      man = raw[22:0];
      if (raw[31] || ex == EXP_SPECIAL || raw[30:0] == 0) begin
        bad = 1'b1;
        return 0;
      end
      if (ex == 0) ex = 8'd1;
      else man |= 64'h80_0000;
      if (ex >= EXP_SATURATE) return 64'hFF_FFFF_FFFF;
      return (man << 8) >> (EXP_POINT - ex);
    endfunction

    function void take_source_pixel(logic [31:0] raw);
      int unsigned     w, h, ow, oh;
      bit              row_hit, col_hit, last_col, bad;
      longint unsigned mx, d;
      kept_pixel_t     px;
      w  = fit_size(regs.source_width, DEF_MAX_WIDTH);
      h  = fit_size(regs.source_height, DEF_MAX_HEIGHT);
      ow = fit_size(regs.dst_width, w);
      oh = fit_size(regs.dst_height, h);
      row_hit = dst_row < oh && 64'(row_target) < 64'(row_base) + 64'(oh);
      col_hit = dst_col < ow && 64'(col_target) < 64'(col_base) + 64'(ow);
      if (row_hit && col_hit) begin
        mx = (regs.depth_limit != 0) ? 64'(regs.depth_limit) : 64'd1;
        d = depth_q16(raw, bad);
        if (bad || d > mx) d = mx;
        last_col = (dst_col + 1 == ow);
        px.depth = 17'((d << 16) / mx);
        px.row_end = last_col;
        px.frame_end = last_col && (dst_row + 1 == oh);
        due.push_back(px);
        dst_col++;
        col_target += w;
      end
      col_base += ow;
      if (src_col + 1 >= w) begin
        src_col = 0;
        dst_col = 0;
        col_base = 0;
        col_target = 0;
        if (row_hit) begin
          dst_row++;
          row_target += h;
        end
        row_base += oh;
        if (src_row + 1 >= h) begin
          src_row = 0;
          dst_row = 0;
          row_base = 0;
          row_target = 0;
        end else begin
          src_row++;
        end
      end else begin
        src_col++;
      end
    endfunction

    function void note_failure(string msg);
      errors++;
      if (errors <= MAX_REPORTS) $display("ERROR %0t: %s", $time, msg);
    endfunction

    function void match_output_pixel(logic [16:0] depth, logic row_end, logic frame_end);
      kept_pixel_t want;
      if (due.size() == 0) begin
        note_failure($sformatf("unexpected output depth=%0d row_end=%b frame_end=%b",
                               depth, row_end, frame_end));
        return;
      end
      want = due.pop_front();
      checked++;
      if (depth !== want.depth || row_end !== want.row_end || frame_end !== want.frame_end)
        note_failure($sformatf(
          "pixel %0d: expected depth=%0d row_end=%b frame_end=%b, got %0d %b %b",
          checked, want.depth, want.row_end, want.frame_end, depth, row_end, frame_end));
    endfunction

    function int outstanding();
      return due.size();
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic [31:0] in_raw_sample;
  logic        out_valid;
  logic        out_stall;
  logic [16:0] out_normalized_depth;
  logic        out_row_end;
  logic        out_frame_end;

  depth_tracker tracker = new();
  int send_idle_pct;
  int stall_pct;
  int items_sent;
  int reg_writes;
  int settings_used;

  depth_decimate_normalize_top dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_raw_sample        (in_raw_sample),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_normalized_depth (out_normalized_depth),
    .out_row_end          (out_row_end),
    .out_frame_end        (out_frame_end)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function void set_idling(idle_mode_t m);
    send_idle_pct = (m == IDLE_SENDER) ? 50 : (m == IDLE_BOTH) ? 22 : 0;
    stall_pct     = (m == IDLE_RECEIVER) ? 50 : (m == IDLE_BOTH) ? 22 : 0;
  endfunction

  task automatic send_pixel(input logic [31:0] raw);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_raw_sample <= raw;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tracker.take_source_pixel(raw);
    items_sent++;
  endtask

  // valid is left high so back-to-back writes need no gap
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    tracker.set_reg(idx, data);
    reg_writes++;
  endtask

  task automatic program_frame(input logic [12:0] w, input logic [12:0] h,
                               input logic [12:0] ow, input logic [12:0] oh,
                               input logic enc, input logic [23:0] scale,
                               input logic [31:0] maxd);
    logic [31:0] hi;
    // unused upper data bits carry noise half the time
    hi = $urandom_range(1) ? $urandom() : 32'd0;
    write_reg(REG_SOURCE_WIDTH,   {hi[31:13], w});
    write_reg(REG_SOURCE_HEIGHT,  {hi[31:13], h});
    write_reg(REG_DST_WIDTH,      {hi[31:13], ow});
    write_reg(REG_DST_HEIGHT,     {hi[31:13], oh});
    write_reg(REG_DEPTH_ENCODING, {hi[31:1], enc});
    write_reg(REG_DEPTH_SCALE,    {hi[31:24], scale});
    write_reg(REG_DEPTH_LIMIT,    maxd);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  // hold the input until every kept pixel is back, then let the pipe empty
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.outstanding() != 0) @(posedge clk);
    repeat (HOLD_OFF) @(posedge clk);
  endtask

  function automatic logic [31:0] random_pixel(logic enc);
    logic [31:0] v;
    v = $urandom();
    if (enc == ENC_COUNT) begin
      case ($urandom_range(7))
        0: v[15:0] = '0;
        1: v[15:0] = '1;
        default: ;
      endcase
    end else begin
      case ($urandom_range(15))
        0: v = FLOAT_CASES[$urandom_range(15)];
        1: ;
        2: v[31] = 1'b1;
        3: v[31:23] = '0;
        default: begin
          v[31] = 1'b0;
          v[30:23] = 8'($urandom_range(100, 150));
        end
      endcase
    end
    return v;
  endfunction

  initial begin : sink
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall)
        tracker.match_output_pixel(out_normalized_depth, out_row_end, out_frame_end);
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("depth_decimate_normalize_top test failed");
    $finish;
  end

  initial begin : stimulus
    logic [12:0] w, h, ow, oh;
    logic        enc;
    logic [23:0] scale;
    logic [31:0] maxd;
    rst_n <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_SOURCE_WIDTH;
    cfg_data <= '0;
    in_valid <= 1'b0;
    in_raw_sample <= '0;
    items_sent = 0;
    reg_writes = 0;
    settings_used = 0;
    set_idling(IDLE_NONE);
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // counts under the reset settings: every pixel of a 640 wide row is kept
    for (int i = 0; i < 7; i++) send_pixel(COUNT_CASES[i]);
    settle();

    program_frame(13'd4, 13'd4, 13'd4, 13'd4, ENC_FLOAT, 24'd1, 32'h0100_0000);
    // first pixel only closes the row left open above
    send_pixel(32'h3F80_0000);
    for (int i = 0; i < 16; i++) send_pixel(FLOAT_CASES[i]);
    settle();

    // zero sizes clamp to 1x1, zero scale and zero limit fall back
    set_idling(IDLE_RECEIVER);
    program_frame('0, '0, '0, '0, ENC_COUNT, '0, '0);
    repeat (60) send_pixel(random_pixel(ENC_COUNT));
    settle();

    // oversized registers clamp to the largest frame; partial first row only
    set_idling(IDLE_SENDER);
    program_frame('1, '1, '1, 13'd4096, ENC_FLOAT, '1, '1);
    repeat (200) send_pixel(random_pixel(ENC_FLOAT));
    settle();

    for (int p = 0; p < 8; p++) begin
      set_idling(idle_mode_t'(p % 4));
      enc = logic'((p >> 2) ^ (p & 1));
      w  = 13'($urandom_range(1, 24));
      h  = 13'($urandom_range(1, 12));
      ow = 13'($urandom_range(1, w + 3));
      oh = 13'($urandom_range(1, h + 2));
      case ($urandom_range(4))
        0: scale = '1;
        1: scale = '0;
        2: scale = 24'd1;
        default: scale = 24'($urandom_range(1000, 40000));
      endcase
      case ($urandom_range(3))
        0: maxd = $urandom();
        1: maxd = $urandom_range(1, 32'h000F_FFFF);
        2: maxd = $urandom_range(1) ? '1 : 32'd1;
        default: maxd = $urandom_range(32'h0001_0000, 32'h0080_0000);
      endcase
      program_frame(w, h, ow, oh, enc, scale, maxd);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (k == PHASE_ITEMS / 2 && p % 2 == 0) settle();
        send_pixel(random_pixel(enc));
      end
      settle();
    end

    $display("%0d source pixels over %0d settings, %0d register writes, %0d kept pixels checked",
             items_sent, settings_used, reg_writes, tracker.checked);
    if (tracker.errors == 0 && tracker.outstanding() == 0) begin
      $display("depth_decimate_normalize_top test passed");
    end else begin
      $display("%0d mismatches", tracker.errors);
      $display("depth_decimate_normalize_top test failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/ddn_pkg.sv
rtl/ddn_regs.sv
rtl/ddn_front.sv
rtl/ddn_queue.sv
rtl/ddn_back.sv
rtl/depth_decimate_normalize_top.sv
test/tb_top.sv
